// ===== rtl/nvme_queue_pair_doorbell_tracker_macros.svh =====
// ---------------------------------------------------------------------------
// Doorbell tracker assertion macros
// Shared concurrent assertion forms for the queue pair tracker checkers.
// ---------------------------------------------------------------------------
`ifndef NVME_QUEUE_PAIR_DOORBELL_TRACKER_MACROS_SVH
`define NVME_QUEUE_PAIR_DOORBELL_TRACKER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NVQP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define NVQP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nvqp_pkg.sv =====
// ---------------------------------------------------------------------------
// Queue pair tracker package
// Beat types, codes, defaults and small helpers shared by the tracker.
// ---------------------------------------------------------------------------
package nvqp_pkg;

    localparam int ADMIN_QUEUE_DEPTH_DEF = 32;
    localparam int IO_QUEUE_DEPTH_DEF    = 64;
    localparam int MAX_IO_QUEUES_DEF     = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [20:0] DB_BASE = 21'h001000;

    // command kinds
    localparam logic [1:0] KIND_ADMIN_SUBMIT = 2'd0;
    localparam logic [1:0] KIND_IO_SUBMIT    = 2'd1;
    localparam logic [1:0] KIND_COMPLETION   = 2'd2;

    // register index (paddr[2])
    localparam logic REG_STRIDE_EXP = 1'b0;
    localparam logic REG_ACTIVE_IO  = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  queue_id;
        logic [15:0] entry_status;
    } cmd_item_t;

    typedef struct packed {
        logic        accepted;
        logic        error_flag;
        logic [2:0]  chosen_queue;
        logic [5:0]  slot_index;
        logic [15:0] command_tag;
        logic [20:0] doorbell_offset;
        logic [5:0]  doorbell_value;
        logic [14:0] completion_code;
    } rsp_item_t;

    typedef struct packed {
        logic [3:0] stride_exp;
        logic [2:0] active_io;
    } cfg_t;

    // a mod b for small values by repeated subtract; a < 8
    function automatic logic [3:0] mod_small(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] r;
        r = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b != 4'd0 && r >= b)
            begin
                r = r - b;
            end
        end
        return r;
    endfunction

    // 0x1000 + idx * (4 << stride_exp), kept to 21 bits
    function automatic logic [20:0] calc_doorbell(input logic [4:0] idx,
                                                  input logic [3:0] stride_exp);
        logic [4:0]  sh;
        logic [20:0] prod;
        sh   = {1'b0, stride_exp} + 5'd2;
        prod = 21'(idx) << sh;
        return prod + DB_BASE;
    endfunction

endpackage

// ===== rtl/nvqp_cfg.sv =====
// ---------------------------------------------------------------------------
// Queue pair tracker register file
// APB-style write/read of doorbell stride exponent and active I/O count.
// ---------------------------------------------------------------------------
module nvqp_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nvqp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nvqp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nvqp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output nvqp_pkg::cfg_t                   cfg
);

    logic [3:0] stride_exp_reg;
    logic [2:0] active_io_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_exp_reg <= 4'd0;
            active_io_reg  <= 3'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                nvqp_pkg::REG_STRIDE_EXP: stride_exp_reg <= pwdata[3:0];
                nvqp_pkg::REG_ACTIVE_IO:  active_io_reg  <= pwdata[2:0];
                default:                  stride_exp_reg <= stride_exp_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            nvqp_pkg::REG_STRIDE_EXP: prdata = 32'(stride_exp_reg);
            nvqp_pkg::REG_ACTIVE_IO:  prdata = 32'(active_io_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.stride_exp = stride_exp_reg;
    assign cfg.active_io  = active_io_reg;

endmodule

// ===== rtl/nvqp_engine.sv =====
// ---------------------------------------------------------------------------
// Queue pair tracker engine
// Per-queue tail/head/phase/tag state and the single-pass result logic.
// ---------------------------------------------------------------------------
module nvqp_engine
#(
    parameter int ADMIN_QUEUE_DEPTH = nvqp_pkg::ADMIN_QUEUE_DEPTH_DEF,
    parameter int IO_QUEUE_DEPTH    = nvqp_pkg::IO_QUEUE_DEPTH_DEF,
    parameter int MAX_IO_QUEUES     = nvqp_pkg::MAX_IO_QUEUES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  nvqp_pkg::cfg_t      cfg,
    input  nvqp_pkg::cmd_item_t item,
    input  logic                commit,
    output nvqp_pkg::rsp_item_t result
);

    localparam int NQ  = MAX_IO_QUEUES + 1;
    localparam int QW  = $clog2(NQ);
    localparam int RRW = (MAX_IO_QUEUES > 1) ? $clog2(MAX_IO_QUEUES) : 1;
    localparam logic [3:0] MAXQ      = 4'(MAX_IO_QUEUES);
    localparam logic [6:0] ADMIN_D7  = 7'(ADMIN_QUEUE_DEPTH);
    localparam logic [6:0] IO_D7     = 7'(IO_QUEUE_DEPTH);

    logic [5:0]     tail_reg  [NQ];
    logic [5:0]     head_reg  [NQ];
    logic           phase_reg [NQ];
    logic [15:0]    tag_reg   [NQ];
    logic [RRW-1:0] rr_ptr_reg;
    logic [RRW-1:0] rr_ptr_next;

    logic [3:0]    n4;
    logic [3:0]    rr_idx4;
    logic [3:0]    rr_inc4;
    logic [3:0]    qid4;
    logic [3:0]    q4;
    logic          io_ok;
    logic          q_ok;
    logic [QW-1:0] q_sel;
    logic [6:0]    depth7;
    logic [5:0]    slot;
    logic [5:0]    head;
    logic [6:0]    tail_inc;
    logic [6:0]    head_inc;
    logic [5:0]    tail_next;
    logic [5:0]    head_next;
    logic          phase_hit;
    logic          sub_we;
    logic          cpl_we;
    logic          rr_we;

    assign n4      = ({1'b0, cfg.active_io} > MAXQ) ? MAXQ : {1'b0, cfg.active_io};
    assign io_ok   = (n4 != 4'd0);
    assign rr_idx4 = nvqp_pkg::mod_small(4'(rr_ptr_reg), n4);
    assign rr_inc4 = rr_idx4 + 4'd1;
    assign rr_ptr_next = (rr_inc4 == n4) ? '0 : rr_inc4[RRW-1:0];
    assign qid4    = {1'b0, item.queue_id};

    always_comb
    begin
        unique case (item.kind)
            nvqp_pkg::KIND_ADMIN_SUBMIT:
            begin
                q4   = 4'd0;
                q_ok = 1'b1;
            end
            nvqp_pkg::KIND_IO_SUBMIT:
            begin
                q4   = rr_inc4;
                q_ok = io_ok;
            end
            nvqp_pkg::KIND_COMPLETION:
            begin
                q4   = qid4;
                q_ok = (qid4 <= n4);
            end
            default:
            begin
                q4   = 4'd0;
                q_ok = 1'b0;
            end
        endcase
    end

    assign q_sel  = q_ok ? q4[QW-1:0] : '0;
    assign depth7 = (q4 == 4'd0) ? ADMIN_D7 : IO_D7;

    assign slot      = tail_reg[q_sel];
    assign head      = head_reg[q_sel];
    assign tail_inc  = {1'b0, slot} + 7'd1;
    assign head_inc  = {1'b0, head} + 7'd1;
    assign tail_next = (tail_inc == depth7) ? 6'd0 : tail_inc[5:0];
    assign head_next = (head_inc == depth7) ? 6'd0 : head_inc[5:0];
    assign phase_hit = (item.entry_status[0] == phase_reg[q_sel]);

    always_comb
    begin
        result = '0;
        unique case (item.kind) inside
            nvqp_pkg::KIND_ADMIN_SUBMIT, nvqp_pkg::KIND_IO_SUBMIT:
            begin
                if (q_ok)
                begin
                    result.accepted        = 1'b1;
                    result.chosen_queue    = q4[2:0];
                    result.slot_index      = slot;
                    result.command_tag     = tag_reg[q_sel];
                    result.doorbell_offset = nvqp_pkg::calc_doorbell({q4, 1'b0},
                                                                     cfg.stride_exp);
                    result.doorbell_value  = tail_next;
                end
                else
                begin
                    result.error_flag = 1'b1;
                end
            end
            nvqp_pkg::KIND_COMPLETION:
            begin
                result.chosen_queue = item.queue_id;
                if (!q_ok)
                begin
                    result.error_flag = 1'b1;
                end
                else
                begin
                    result.slot_index = head;
                    if (phase_hit)
                    begin
                        result.accepted        = 1'b1;
                        result.doorbell_offset = nvqp_pkg::calc_doorbell({q4, 1'b1},
                                                                         cfg.stride_exp);
                        result.doorbell_value  = head_next;
                        result.completion_code = item.entry_status[15:1];
                    end
                end
            end
            default:
            begin
                result.error_flag = 1'b1;
            end
        endcase
    end

    assign sub_we = commit && q_ok && (item.kind == nvqp_pkg::KIND_ADMIN_SUBMIT ||
                                       item.kind == nvqp_pkg::KIND_IO_SUBMIT);
    assign cpl_we = commit && q_ok && phase_hit && (item.kind == nvqp_pkg::KIND_COMPLETION);
    assign rr_we  = commit && io_ok && (item.kind == nvqp_pkg::KIND_IO_SUBMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                tail_reg[i]  <= 6'd0;
                head_reg[i]  <= 6'd0;
                phase_reg[i] <= 1'b1;
                tag_reg[i]   <= 16'd0;
            end
            rr_ptr_reg <= '0;
        end
        else
        begin
            if (sub_we)
            begin
                tail_reg[q_sel] <= tail_next;
                tag_reg[q_sel]  <= tag_reg[q_sel] + 16'd1;
            end
            if (cpl_we)
            begin
                head_reg[q_sel] <= head_next;
                if (head_next == 6'd0)
                begin
                    phase_reg[q_sel] <= ~phase_reg[q_sel];
                end
            end
            if (rr_we)
            begin
                rr_ptr_reg <= rr_ptr_next;
            end
        end
    end

endmodule

// ===== rtl/nvme_queue_pair_doorbell_tracker.sv =====
// Command beats go input register -> engine -> response register; the two registers
//   part the sides. Throughput: one command beat per cycle unless a response stalls,
//   and even then one more beat is taken while the stalled response waits.
// Reset (rst_n low, async): all tails/heads/tags to 0, phases to 1, round robin
//   pointer to 0, stride exponent 0, one active I/O queue, both stages empty.
// ---------------------------------------------------------------------------
// NVMe queue pair doorbell tracker
// Host-side tail/head/phase/command-id bookkeeping for one admin queue and
// up to MAX_IO_QUEUES I/O queues, producing doorbell offsets and values.
// ---------------------------------------------------------------------------
module nvme_queue_pair_doorbell_tracker
#(
    parameter int ADMIN_QUEUE_DEPTH = nvqp_pkg::ADMIN_QUEUE_DEPTH_DEF,
    parameter int IO_QUEUE_DEPTH    = nvqp_pkg::IO_QUEUE_DEPTH_DEF,
    parameter int MAX_IO_QUEUES     = nvqp_pkg::MAX_IO_QUEUES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nvqp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nvqp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nvqp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // command channel
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  nvqp_pkg::cmd_item_t             cmd,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output nvqp_pkg::rsp_item_t             rsp
);

    nvqp_pkg::cfg_t      cfg;
    nvqp_pkg::cmd_item_t cmd_reg;
    logic                cmd_vld_reg;
    logic                cmd_vld_next;
    nvqp_pkg::rsp_item_t rsp_reg;
    nvqp_pkg::rsp_item_t rsp_next;
    logic                rsp_vld_reg;
    logic                rsp_vld_next;
    logic                rsp_open;
    logic                move;

    nvqp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The response register is free when empty or being drained this cycle.
    // A held command beat moves through the engine only then, and the engine
    // commits its state update at the same edge the response is captured.
    assign rsp_open  = !rsp_vld_reg || !rsp_stall;
    assign move      = cmd_vld_reg && rsp_open;
    // Stall only when the input register holds a beat that cannot move.
    assign cmd_stall = cmd_vld_reg && !rsp_open;

    assign cmd_vld_next = cmd_stall ? cmd_vld_reg : cmd_valid;
    assign rsp_vld_next = rsp_open ? cmd_vld_reg : rsp_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= cmd_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        if (move)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // All per-queue work for one beat: queue pick, pointer wrap, phase check,
    // doorbell offset. State reads see every earlier committed beat.
    nvqp_engine
    #(
        .ADMIN_QUEUE_DEPTH (ADMIN_QUEUE_DEPTH),
        .IO_QUEUE_DEPTH    (IO_QUEUE_DEPTH),
        .MAX_IO_QUEUES     (MAX_IO_QUEUES)
    )
    u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (cmd_reg),
        .commit (move),
        .result (rsp_next)
    );

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/nvqp_checker.sv =====
// ---------------------------------------------------------------------------
// Queue pair tracker checker
// Port-level assertions on the command and response channels.
// ---------------------------------------------------------------------------
`include "nvme_queue_pair_doorbell_tracker_macros.svh"

module nvqp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input nvqp_pkg::cmd_item_t cmd,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input nvqp_pkg::rsp_item_t rsp
);

    logic rsp_idle_fields;
    logic cmd_seen;

    assign cmd_seen        = cmd_valid || (cmd.kind == nvqp_pkg::KIND_ADMIN_SUBMIT);
    assign rsp_idle_fields = (rsp.command_tag == 16'd0) && (rsp.doorbell_offset == 21'd0) &&
                             (rsp.doorbell_value == 6'd0) && (rsp.completion_code == 15'd0);

    // a stalled response beat holds
    `NVQP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response beat changed while stalled")

    // back-pressure on commands only comes from a blocked response
    `NVQP_ASSERT_SAME(a_stall_src, clk, rst_n, cmd_stall || (cmd_seen && cmd_stall), rsp_valid && rsp_stall, "command stalled without a blocked response")

    // a beat is never both consumed and in error
    `NVQP_ASSERT_SAME(a_acc_err, clk, rst_n, rsp_valid, !(rsp.accepted && rsp.error_flag), "accepted and error flag both set")

    // a refused beat carries no doorbell, tag or status
    `NVQP_ASSERT_SAME(a_refused_zero, clk, rst_n, rsp_valid && !rsp.accepted, rsp_idle_fields, "refused beat carries doorbell data")

endmodule

bind nvme_queue_pair_doorbell_tracker nvqp_checker u_nvqp_checker (.*);

// ===== dv/tb_nvme_queue_pair_doorbell_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Queue pair doorbell tracker testbench
// Drives command beats through a clocked driver fed from a backlog, predicts
// each response beat from a private copy of the queue state at the moment the
// command beat is taken, and checks every response beat field by field.
// Register writes happen only with the block drained.
// ---------------------------------------------------------------------------
module tb_nvme_queue_pair_doorbell_tracker;

    localparam int NQ          = nvqp_pkg::MAX_IO_QUEUES_DEF + 1;
    localparam int IDLE_PCT    = 19;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;

    // kind code the block must reject; the package names only the legal ones
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            psel      = 1'b0;
    logic                            penable   = 1'b0;
    logic                            pwrite    = 1'b0;
    logic [nvqp_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [nvqp_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [nvqp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            cmd_valid = 1'b0;
    logic                            cmd_stall;
    nvqp_pkg::cmd_item_t             cmd       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    nvqp_pkg::rsp_item_t             rsp;

    // Stimulus control; calm and hold_req are written by the sequencing block at falling edges
    logic                  calm      = 1'b0;  // no idling on either side
    logic                  hold_req  = 1'b0;  // ask for one long receiver hold
    logic                  hold_done = 1'b0;
    int unsigned           hold_cnt  = 0;

    nvqp_pkg::cmd_item_t   cmd_backlog[$];     // command beats not yet offered
    nvqp_pkg::rsp_item_t   rsp_due[$];         // predicted response beats, oldest first
    nvqp_pkg::rsp_item_t   rsp_want;
    int unsigned           err_count   = 0;
    int unsigned           cycle_count = 0;

    // Private copy of the register file and the per-queue bookkeeping
    logic [3:0]            db_stride_exp = 4'd0;
    logic [2:0]            io_count_cfg  = 3'd1;
    logic [5:0]            sq_tail      [NQ] = '{default: '0};
    logic [5:0]            cq_head      [NQ] = '{default: '0};
    logic                  cq_expect_ph [NQ] = '{default: 1'b1};
    logic [15:0]           cid_next     [NQ] = '{default: '0};
    logic [1:0]            rr_ptr        = 2'd0;

    nvme_queue_pair_doorbell_tracker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    function automatic int unsigned ring_depth(int unsigned q);
        return (q == 0) ? nvqp_pkg::ADMIN_QUEUE_DEPTH_DEF : nvqp_pkg::IO_QUEUE_DEPTH_DEF;
    endfunction

    // register field holds 0..7; anything past the hardware limit saturates
    function automatic int unsigned live_io_queues();
        return (io_count_cfg > nvqp_pkg::MAX_IO_QUEUES_DEF) ?
               nvqp_pkg::MAX_IO_QUEUES_DEF : io_count_cfg;
    endfunction

    // doorbell index 2q is the SQ tail, 2q+1 the CQ head; result wraps at 21 bits
    function automatic logic [20:0] doorbell_at(int unsigned idx);
        longint unsigned stride;
        stride = 64'd4 << db_stride_exp;
        return 21'(64'(nvqp_pkg::DB_BASE) + idx * stride);
    endfunction

    function automatic nvqp_pkg::rsp_item_t take_submit_slot(int unsigned q);
        nvqp_pkg::rsp_item_t r;
        r                 = '0;
        r.accepted        = 1'b1;
        r.chosen_queue    = 3'(q);
        r.slot_index      = sq_tail[q];
        r.command_tag     = cid_next[q];
        cid_next[q]       = cid_next[q] + 16'd1;
        sq_tail[q]        = 6'((sq_tail[q] + 1) % ring_depth(q));
        r.doorbell_offset = doorbell_at(2 * q);
        r.doorbell_value  = sq_tail[q];
        return r;
    endfunction

    // Response beat for one command beat; updates the private state
    function automatic nvqp_pkg::rsp_item_t queue_pair_outcome(nvqp_pkg::cmd_item_t c);
        nvqp_pkg::rsp_item_t r;
        int unsigned         n;
        int unsigned         q;
        int unsigned         nh;
        r = '0;
        n = live_io_queues();
        case (c.kind)
            nvqp_pkg::KIND_ADMIN_SUBMIT:
            begin
                r = take_submit_slot(0);
            end
            nvqp_pkg::KIND_IO_SUBMIT:
            begin
                if (n == 0)
                begin
                    r.error_flag = 1'b1;
                end
                else
                begin
                    // pointer may be stale after a count change, hence the modulo
                    q      = (rr_ptr % n) + 1;
                    rr_ptr = 2'((rr_ptr + 1) % n);
                    r      = take_submit_slot(q);
                end
            end
            nvqp_pkg::KIND_COMPLETION:
            begin
                r.chosen_queue = c.queue_id;
                if (c.queue_id > n)
                begin
                    r.error_flag = 1'b1;
                end
                else
                begin
                    q            = c.queue_id;
                    r.slot_index = cq_head[q];
                    // phase tag mismatch: entry not posted yet, nothing moves
                    if (c.entry_status[0] == cq_expect_ph[q])
                    begin
                        nh         = (cq_head[q] + 1) % ring_depth(q);
                        cq_head[q] = 6'(nh);
                        if (nh == 0)
                        begin
                            cq_expect_ph[q] = ~cq_expect_ph[q];
                        end
                        r.accepted        = 1'b1;
                        r.doorbell_offset = doorbell_at(2 * q + 1);
                        r.doorbell_value  = 6'(nh);
                        r.completion_code = c.entry_status[15:1];
                    end
                end
            end
            default:
            begin
                r.error_flag = 1'b1;
            end
        endcase
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
        begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // -----------------------------------------------------------------------
    // Command driver: predicts at the accepting edge, then offers the next beat.
    // A stalled beat keeps valid and payload untouched.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                rsp_due.push_back(queue_pair_outcome(cmd));
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cmd       <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Response stall: random back-pressure, plus one long hold on request so
    // that both pipeline stages fill and the command side stalls.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            if (hold_cnt == HOLD_CYCLES)
            begin
                hold_done <= 1'b1;
                rsp_stall <= 1'b0;
            end
            else
            begin
                hold_cnt  <= hold_cnt + 1;
                rsp_stall <= 1'b1;
            end
        end
        else
        begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // -----------------------------------------------------------------------
    // Response monitor
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                report_mismatch($sformatf("response beat with none due: 0x%0h", rsp));
            end
            else
            begin
                rsp_want = rsp_due.pop_front();
                check_field("accepted",        32'(rsp.accepted),
                            32'(rsp_want.accepted));
                check_field("error_flag",      32'(rsp.error_flag),
                            32'(rsp_want.error_flag));
                check_field("chosen_queue",    32'(rsp.chosen_queue),
                            32'(rsp_want.chosen_queue));
                check_field("slot_index",      32'(rsp.slot_index),
                            32'(rsp_want.slot_index));
                check_field("command_tag",     32'(rsp.command_tag),
                            32'(rsp_want.command_tag));
                check_field("doorbell_offset", 32'(rsp.doorbell_offset),
                            32'(rsp_want.doorbell_offset));
                check_field("doorbell_value",  32'(rsp.doorbell_value),
                            32'(rsp_want.doorbell_value));
                check_field("completion_code", 32'(rsp.completion_code),
                            32'(rsp_want.completion_code));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout: %0d beats still due", rsp_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencing helpers
    // -----------------------------------------------------------------------

    // Setup + access write, then the same for a read-back of the register
    task automatic program_reg(input logic reg_sel, input logic [31:0] value);
        logic [31:0] stored;
        stored = (reg_sel == nvqp_pkg::REG_STRIDE_EXP) ? (value & 32'hF) : (value & 32'h7);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == nvqp_pkg::REG_STRIDE_EXP)
        begin
            db_stride_exp = stored[3:0];
        end
        else
        begin
            io_count_cfg = stored[2:0];
        end
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("register read-back", prdata, stored);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_cmd(input logic [1:0] kind, input logic [2:0] qid,
                            input logic [15:0] status);
        nvqp_pkg::cmd_item_t c;
        c.kind         = kind;
        c.queue_id     = qid;
        c.entry_status = status;
        cmd_backlog.push_back(c);
    endtask

    // Random beats. Most completions carry the phase tag the host expects, so
    // heads advance and wrap; a shadow of the head/phase keeps that true
    // across the batch. The rest are stale entries or bad queue ids.
    task automatic queue_random(input int unsigned count);
        nvqp_pkg::cmd_item_t c;
        logic [5:0]          sh_head  [NQ];
        logic                sh_phase [NQ];
        int unsigned         n;
        int unsigned         roll;
        int unsigned         q;
        @(negedge clk);
        sh_head  = cq_head;
        sh_phase = cq_expect_ph;
        n        = live_io_queues();
        repeat (count)
        begin
            roll           = $urandom_range(99);
            c.queue_id     = 3'($urandom_range(7));
            c.entry_status = 16'($urandom);
            if (roll < 25)
            begin
                c.kind = nvqp_pkg::KIND_ADMIN_SUBMIT;
            end
            else if (roll < 50)
            begin
                c.kind = nvqp_pkg::KIND_IO_SUBMIT;
            end
            else if (roll < 95)
            begin
                c.kind = nvqp_pkg::KIND_COMPLETION;
                if ($urandom_range(9) != 0)
                begin
                    c.queue_id = 3'($urandom_range(n));
                end
                if (c.queue_id <= n)
                begin
                    q = c.queue_id;
                    if ($urandom_range(99) < 85)
                    begin
                        c.entry_status[0] = sh_phase[q];
                    end
                    if (c.entry_status[0] == sh_phase[q])
                    begin
                        sh_head[q] = 6'((sh_head[q] + 1) % ring_depth(q));
                        if (sh_head[q] == 0)
                        begin
                            sh_phase[q] = ~sh_phase[q];
                        end
                    end
                end
            end
            else
            begin
                c.kind = KIND_UNUSED;
            end
            cmd_backlog.push_back(c);
        end
    endtask

    // Block is idle once nothing is queued, offered or due
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (cmd_backlog.size() != 0 || cmd_valid || rsp_due.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: stride 4, one I/O queue
        @(negedge clk);
        push_cmd(nvqp_pkg::KIND_ADMIN_SUBMIT, 3'd7, 16'hFFFF);
        push_cmd(nvqp_pkg::KIND_IO_SUBMIT,    3'd0, 16'h0000);
        push_cmd(nvqp_pkg::KIND_IO_SUBMIT,    3'd5, 16'h8000);
        push_cmd(nvqp_pkg::KIND_COMPLETION,   3'd0, 16'hFFFF);   // phase match, max status
        push_cmd(nvqp_pkg::KIND_COMPLETION,   3'd0, 16'h0000);   // stale phase tag
        push_cmd(nvqp_pkg::KIND_COMPLETION,   3'd1, 16'h0001);   // match, zero status
        push_cmd(nvqp_pkg::KIND_COMPLETION,   3'd2, 16'h0001);   // queue not active
        push_cmd(nvqp_pkg::KIND_COMPLETION,   3'd7, 16'hFFFF);   // beyond any queue
        push_cmd(KIND_UNUSED,                 3'd7, 16'hFFFF);
        wait_drained();

        // Widest stride, all four queues: round robin wraps, largest offsets
        program_reg(nvqp_pkg::REG_STRIDE_EXP, 32'd15);
        program_reg(nvqp_pkg::REG_ACTIVE_IO,  32'd4);
        @(negedge clk);
        repeat (5)
        begin
            push_cmd(nvqp_pkg::KIND_IO_SUBMIT, 3'd0, 16'h0000);
        end
        push_cmd(nvqp_pkg::KIND_COMPLETION, 3'd4, 16'h5555);
        push_cmd(nvqp_pkg::KIND_COMPLETION, 3'd5, 16'hAAAB);
        wait_drained();
        queue_random(150);
        wait_drained();

        // No I/O queue up: I/O submits and I/O completions are errors
        program_reg(nvqp_pkg::REG_STRIDE_EXP, 32'd0);
        program_reg(nvqp_pkg::REG_ACTIVE_IO,  32'd0);
        @(negedge clk);
        push_cmd(nvqp_pkg::KIND_IO_SUBMIT,  3'd1, 16'h0001);
        push_cmd(nvqp_pkg::KIND_COMPLETION, 3'd1, 16'h0001);
        push_cmd(nvqp_pkg::KIND_COMPLETION, 3'd0, 16'h0001);
        wait_drained();
        queue_random(60);
        wait_drained();

        // Count above the hardware limit saturates; long stretch without idling
        program_reg(nvqp_pkg::REG_STRIDE_EXP, 32'd5);
        program_reg(nvqp_pkg::REG_ACTIVE_IO,  32'd7);
        @(negedge clk);
        calm = 1'b1;
        repeat (5)
        begin
            push_cmd(nvqp_pkg::KIND_IO_SUBMIT, 3'd0, 16'h0000);
        end
        push_cmd(nvqp_pkg::KIND_COMPLETION, 3'd5, 16'h0001);
        wait_drained();
        queue_random(200);
        wait_drained();
        calm = 1'b0;

        // Three queues; the receiver holds off early in this batch
        program_reg(nvqp_pkg::REG_STRIDE_EXP, 32'd3);
        program_reg(nvqp_pkg::REG_ACTIVE_IO,  32'd3);
        @(negedge clk);
        hold_req = 1'b1;
        queue_random(200);
        wait_drained();

        program_reg(nvqp_pkg::REG_STRIDE_EXP, 32'd15);
        program_reg(nvqp_pkg::REG_ACTIVE_IO,  32'd2);
        queue_random(200);
        wait_drained();

        // let any stray response beat show up before judging
        repeat (4) @(posedge clk);
        if (err_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
